// ===== rtl/vcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// vcbs_pkg
// Shared types and constants for the VGM command bus sequencer.
// ----------------------------------------------------------------------------
package vcbs_pkg;

	localparam logic [1:0] OP_RUN    = 2'd0;
	localparam logic [1:0] OP_RESET  = 2'd1;
	localparam logic [1:0] OP_START  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [7:0] CMD_SILENT   = 8'h4f;
	localparam logic [7:0] CMD_PSG      = 8'h50;
	localparam logic [7:0] CMD_FM_PORT0 = 8'h52;
	localparam logic [7:0] CMD_FM_PORT1 = 8'h53;
	localparam logic [7:0] CMD_WAIT     = 8'h61;
	localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
	localparam logic [7:0] CMD_WAIT_PAL = 8'h63;
	localparam logic [7:0] CMD_SHORT_LO = 8'h70;
	localparam logic [7:0] CMD_SHORT_HI = 8'h7f;
	localparam logic [7:0] CMD_DAC_LO   = 8'h80;
	localparam logic [7:0] CMD_DAC_HI   = 8'h8f;
	localparam logic [7:0] CMD_NOP_LO   = 8'h90;
	localparam logic [7:0] CMD_NOP_HI   = 8'h95;

	localparam logic [15:0] WAIT_NTSC = 16'd735;
	localparam logic [15:0] WAIT_PAL  = 16'd882;
	localparam logic [7:0]  DAC_REG   = 8'h2a;

	localparam logic [7:0] CTL_PSG_CS = 8'h01;
	localparam logic [7:0] CTL_IC     = 8'h02;
	localparam logic [7:0] CTL_WR     = 8'h04;
	localparam logic [7:0] CTL_A0     = 8'h08;
	localparam logic [7:0] CTL_A1     = 8'h10;
	localparam logic [7:0] CTL_FM_CS  = 8'h20;
	localparam logic [7:0] CTL_RESET  = 8'hff;

	localparam logic [7:0] MUTE_CH0 = 8'h9f;
	localparam logic [7:0] MUTE_CH1 = 8'hbf;
	localparam logic [7:0] MUTE_CH2 = 8'hdf;
	localparam logic [7:0] MUTE_CH3 = 8'hff;

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_PSG,
		KIND_FM,
		KIND_RESET
	} kind_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] command_byte;
		logic [7:0] arg_one;
		logic [7:0] arg_two;
		logic [7:0] pcm_byte;
	} cmd_t;

	typedef struct packed {
		logic        bus_valid;
		logic [7:0]  control_out;
		logic [7:0]  data_out;
		logic [31:0] next_sample_out;
		logic        error;
		logic        last;
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic        port1;
		logic [7:0]  byte_a;
		logic [7:0]  byte_b;
		logic        err;
		logic [31:0] next_sample;
	} desc_t;

	function automatic logic [7:0] bit_reverse(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

endpackage

// ===== rtl/vcbs_front.sv =====
// ----------------------------------------------------------------------------
// vcbs_front
// Classifies each request and keeps the next-sample counter.
// ----------------------------------------------------------------------------
module vcbs_front import vcbs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	input  cmd_t  cmd,
	output logic  cmd_stall,
	input  logic  full,
	output logic  push,
	output desc_t desc
);

	logic [31:0] ns_q;
	logic [31:0] ns_next;
	logic [15:0] add;
	logic        clear;

	always_comb begin
		desc        = '0;
		desc.kind   = KIND_IDLE;
		add         = '0;
		clear       = 1'b0;
		unique case (cmd.op)
			OP_RUN: begin
				case (cmd.command_byte) inside
					CMD_PSG: begin
						desc.kind   = KIND_PSG;
						desc.byte_a = cmd.arg_one;
					end
					CMD_FM_PORT0, CMD_FM_PORT1: begin
						desc.kind   = KIND_FM;
						desc.port1  = (cmd.command_byte == CMD_FM_PORT1);
						desc.byte_a = cmd.arg_one;
						desc.byte_b = cmd.arg_two;
					end
					CMD_WAIT:      add = {cmd.arg_two, cmd.arg_one};
					CMD_WAIT_NTSC: add = WAIT_NTSC;
					CMD_WAIT_PAL:  add = WAIT_PAL;
					[CMD_SHORT_LO:CMD_SHORT_HI]: begin
						add = 16'(cmd.command_byte[3:0]) + 16'd1;
					end
					[CMD_DAC_LO:CMD_DAC_HI]: begin
						desc.kind   = KIND_FM;
						desc.byte_a = DAC_REG;
						desc.byte_b = cmd.pcm_byte;
						add         = 16'(cmd.command_byte[3:0]);
					end
					CMD_SILENT, [CMD_NOP_LO:CMD_NOP_HI]: ;
					default: desc.err = 1'b1;
				endcase
			end
			OP_RESET: desc.kind = KIND_RESET;
			OP_START: clear = 1'b1;
			default: ;
		endcase
		ns_next          = clear ? '0 : ns_q + 32'(add);
		desc.next_sample = ns_next;
	end

	assign cmd_stall = full;
	assign push      = cmd_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_q <= '0;
		end else if (push) begin
			ns_q <= ns_next;
		end
	end

endmodule

// ===== rtl/vcbs_queue.sv =====
// ----------------------------------------------------------------------------
// vcbs_queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module vcbs_queue import vcbs_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output desc_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t         mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/vcbs_back.sv =====
// ----------------------------------------------------------------------------
// vcbs_back
// Steps the control and data shift registers through each bus phase.
// ----------------------------------------------------------------------------
module vcbs_back import vcbs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   head_valid,
	input  desc_t  head,
	output logic   pop,
	output logic   phase_valid,
	output phase_t phase,
	input  logic   phase_stall
);

	typedef enum logic [3:0] {
		U_NONE,
		U_PSG0,
		U_PSG1,
		U_PSG2,
		U_FM0,
		U_FM1,
		U_FM2,
		U_FM3,
		U_FM4,
		U_IC0,
		U_IC1
	} uop_t;

	logic [7:0] ctl_q;
	logic [7:0] dat_q;
	logic [3:0] step_q;
	logic       out_valid_q;
	phase_t     out_q;

	logic       adv;
	logic       fire;
	logic       last;
	uop_t       uop;
	logic [7:0] psg_val;
	logic [7:0] nctl;
	logic [7:0] ndat;

	always_comb begin
		uop     = U_NONE;
		psg_val = head.byte_a;
		last    = 1'b1;
		unique case (head.kind)
			KIND_IDLE: uop = U_NONE;
			KIND_PSG: begin
				last = (step_q == 4'd2);
				case (step_q)
					4'd0:    uop = U_PSG0;
					4'd1:    uop = U_PSG1;
					default: uop = U_PSG2;
				endcase
			end
			KIND_FM: begin
				last = (step_q == 4'd4);
				case (step_q)
					4'd0:    uop = U_FM0;
					4'd1:    uop = U_FM1;
					4'd2:    uop = U_FM2;
					4'd3:    uop = U_FM3;
					default: uop = U_FM4;
				endcase
			end
			KIND_RESET: begin
				last = (step_q == 4'd13);
				case (step_q)
					4'd0:  uop = U_IC0;
					4'd1:  uop = U_IC1;
					4'd2:  begin uop = U_PSG0; psg_val = MUTE_CH0; end
					4'd3:  begin uop = U_PSG1; psg_val = MUTE_CH0; end
					4'd4:  begin uop = U_PSG2; psg_val = MUTE_CH0; end
					4'd5:  begin uop = U_PSG0; psg_val = MUTE_CH1; end
					4'd6:  begin uop = U_PSG1; psg_val = MUTE_CH1; end
					4'd7:  begin uop = U_PSG2; psg_val = MUTE_CH1; end
					4'd8:  begin uop = U_PSG0; psg_val = MUTE_CH2; end
					4'd9:  begin uop = U_PSG1; psg_val = MUTE_CH2; end
					4'd10: begin uop = U_PSG2; psg_val = MUTE_CH2; end
					4'd11: begin uop = U_PSG0; psg_val = MUTE_CH3; end
					4'd12: begin uop = U_PSG1; psg_val = MUTE_CH3; end
					default: begin uop = U_PSG2; psg_val = MUTE_CH3; end
				endcase
			end
			default: uop = U_NONE;
		endcase
	end

	always_comb begin
		nctl = ctl_q;
		ndat = dat_q;
		unique case (uop)
			U_NONE: ;
			U_PSG0: begin
				nctl = ctl_q & ~(CTL_PSG_CS | CTL_WR);
				ndat = bit_reverse(psg_val);
			end
			U_PSG1: nctl = ctl_q | CTL_WR;
			U_PSG2: nctl = ctl_q | CTL_PSG_CS;
			U_FM0:  nctl = (head.port1 ? (ctl_q | CTL_A1) : (ctl_q & ~CTL_A1)) & ~CTL_A0;
			U_FM1: begin
				nctl = ctl_q & ~(CTL_FM_CS | CTL_WR);
				ndat = head.byte_a;
			end
			U_FM2:  nctl = ctl_q | CTL_WR;
			U_FM3: begin
				nctl = (ctl_q | CTL_A0) & ~CTL_WR;
				ndat = head.byte_b;
			end
			U_FM4:  nctl = ctl_q | CTL_WR | CTL_FM_CS;
			U_IC0:  nctl = ctl_q ^ CTL_IC;
			U_IC1:  nctl = ctl_q | CTL_IC;
			default: ;
		endcase
	end

	assign adv         = !out_valid_q || !phase_stall;
	assign fire        = adv && head_valid;
	assign pop         = fire && last;
	assign phase_valid = out_valid_q;
	assign phase       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= CTL_RESET;
			dat_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			ctl_q       <= nctl;
			dat_q       <= ndat;
			step_q      <= last ? '0 : step_q + 1'b1;
			out_valid_q <= 1'b1;
		end else if (adv) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.bus_valid       <= (head.kind != KIND_IDLE);
			out_q.control_out     <= nctl;
			out_q.data_out        <= ndat;
			out_q.next_sample_out <= head.next_sample;
			out_q.error           <= head.err;
			out_q.last            <= last;
		end
	end

endmodule

// ===== rtl/vgm_command_bus_sequencer.sv =====
// ----------------------------------------------------------------------------
// vgm_command_bus_sequencer
// Turns decoded VGM commands into control and data shift-register phases.
//
// Request channel (cmd_valid, cmd_stall, cmd): one decoded command, a chip
// reset sequence or a playback start per request. Result channel
// (phase_valid, phase_stall, phase): one result per bus phase, or a single
// non-bus result for waits, silent, unknown and control requests; the
// final result of each request has last set.
// A taken request passes through the queue to the result register. The back
// end gives one result per cycle unless the queue is empty or the receiver
// stalls; a PSG write has 3 results, FM or DAC 5, chip reset 14, other 1.
// The front end classifies requests and keeps the next-sample counter; a
// QUEUE_DEPTH-entry queue lets it take new requests while the back end
// works. When the receiver stalls the result register holds and the queue
// fills; cmd_stall rises once it is full.
// Reset: control register 0xff, data register and counter cleared, queue
// and result register emptied.
// ----------------------------------------------------------------------------
module vgm_command_bus_sequencer import vcbs_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	output logic   cmd_stall,
	input  cmd_t   cmd,
	output logic   phase_valid,
	input  logic   phase_stall,
	output phase_t phase
);

	logic  full;
	logic  push;
	logic  pop;
	logic  head_valid;
	desc_t desc;
	desc_t head;

	vcbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.full      (full),
		.push      (push),
		.desc      (desc)
	);

	vcbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wdata      (desc),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	vcbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.phase_valid (phase_valid),
		.phase       (phase),
		.phase_stall (phase_stall)
	);

endmodule

// ===== tb/vgm_command_bus_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// vgm_command_bus_sequencer_test
// Self-checking bench for the VGM command bus sequencer. A directed set of
// requests covers every opcode class, the field extremes, chip reset,
// playback start and the unused op. A weighted random stream follows.
// Each accepted request is run through a local model of the control and
// data registers and the next-sample counter. The model's bus phases are
// queued and compared field by field with every accepted result. Both
// channels idle and stall at random, except in one calm window.
// ----------------------------------------------------------------------------
module vgm_command_bus_sequencer_test import vcbs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 420;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_PHASES      = 14;
	localparam int IDLE_PERCENT    = 22;

	logic   clk;
	logic   arst_n;
	logic   cmd_valid;
	logic   cmd_stall;
	cmd_t   cmd;
	logic   phase_valid;
	logic   phase_stall;
	phase_t phase;

	cmd_t   pending_cmds[$];
	phase_t phases_due[$];

	logic [7:0]  ctl_model;
	logic [7:0]  data_model;
	logic [31:0] sample_model;
	phase_t      phase_buf[MAX_PHASES];
	int          phase_cnt;
	phase_t      due_phase;

	int  mismatches;
	int  requests_taken;
	int  cycle_count;
	logic req_taken;
	logic calm;

	vgm_command_bus_sequencer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.phase_valid (phase_valid),
		.phase_stall (phase_stall),
		.phase       (phase)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	assign calm = (requests_taken >= 150) && (requests_taken < 240);

	function automatic logic [7:0] flip_bits(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = v[i];
		end
		return r;
	endfunction

	task automatic emit_bus_phase();
		phase_t p;
		p = '0;
		p.bus_valid = 1'b1;
		p.control_out = ctl_model;
		p.data_out = data_model;
		if (phase_cnt < MAX_PHASES) begin
			phase_buf[phase_cnt] = p;
			phase_cnt++;
		end
	endtask

	task automatic psg_write(input logic [7:0] v);
		ctl_model = ctl_model & ~(CTL_PSG_CS | CTL_WR);
		data_model = flip_bits(v);
		emit_bus_phase();
		ctl_model = ctl_model | CTL_WR;
		emit_bus_phase();
		ctl_model = ctl_model | CTL_PSG_CS;
		emit_bus_phase();
	endtask

	task automatic fm_write(input logic port1, input logic [7:0] reg_addr,
			input logic [7:0] value);
		if (port1) begin
			ctl_model = ctl_model | CTL_A1;
		end else begin
			ctl_model = ctl_model & ~CTL_A1;
		end
		ctl_model = ctl_model & ~CTL_A0;
		emit_bus_phase();
		ctl_model = ctl_model & ~(CTL_FM_CS | CTL_WR);
		data_model = reg_addr;
		emit_bus_phase();
		ctl_model = ctl_model | CTL_WR;
		emit_bus_phase();
		ctl_model = (ctl_model | CTL_A0) & ~CTL_WR;
		data_model = value;
		emit_bus_phase();
		ctl_model = ctl_model | CTL_WR | CTL_FM_CS;
		emit_bus_phase();
	endtask

	task automatic sequence_phases(input cmd_t c);
		logic   known;
		phase_t p;
		known = 1'b1;
		phase_cnt = 0;
		case (c.op)
			OP_RUN: begin
				if (c.command_byte == CMD_PSG) begin
					psg_write(c.arg_one);
				end else if (c.command_byte == CMD_FM_PORT0
						|| c.command_byte == CMD_FM_PORT1) begin
					fm_write(c.command_byte == CMD_FM_PORT1, c.arg_one, c.arg_two);
				end else if (c.command_byte == CMD_WAIT) begin
					sample_model = sample_model + {16'd0, c.arg_two, c.arg_one};
				end else if (c.command_byte == CMD_WAIT_NTSC) begin
					sample_model = sample_model + {16'd0, WAIT_NTSC};
				end else if (c.command_byte == CMD_WAIT_PAL) begin
					sample_model = sample_model + {16'd0, WAIT_PAL};
				end else if (c.command_byte >= CMD_SHORT_LO
						&& c.command_byte <= CMD_SHORT_HI) begin
					sample_model = sample_model + {28'd0, c.command_byte[3:0]} + 32'd1;
				end else if (c.command_byte >= CMD_DAC_LO
						&& c.command_byte <= CMD_DAC_HI) begin
					fm_write(1'b0, DAC_REG, c.pcm_byte);
					sample_model = sample_model + {28'd0, c.command_byte[3:0]};
				end else if (c.command_byte == CMD_SILENT
						|| (c.command_byte >= CMD_NOP_LO && c.command_byte <= CMD_NOP_HI)) begin
					known = 1'b1;
				end else begin
					known = 1'b0;
				end
			end
			OP_RESET: begin
				ctl_model = ctl_model ^ CTL_IC;
				emit_bus_phase();
				ctl_model = ctl_model | CTL_IC;
				emit_bus_phase();
				psg_write(MUTE_CH0);
				psg_write(MUTE_CH1);
				psg_write(MUTE_CH2);
				psg_write(MUTE_CH3);
			end
			OP_START: begin
				sample_model = '0;
			end
			default: begin
				known = 1'b1;
			end
		endcase
		if (phase_cnt == 0) begin
			p = '0;
			p.control_out = ctl_model;
			p.data_out = data_model;
			phase_buf[0] = p;
			phase_cnt = 1;
		end
		for (int k = 0; k < phase_cnt; k++) begin
			p = phase_buf[k];
			p.next_sample_out = sample_model;
			p.error = ~known;
			p.last = (k == phase_cnt - 1);
			phases_due.push_back(p);
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycle_count);
		mismatches++;
	endtask

	function automatic cmd_t make_request(input logic [1:0] op, input logic [7:0] c,
			input logic [7:0] a1, input logic [7:0] a2, input logic [7:0] pcm);
		cmd_t r;
		r.op = op;
		r.command_byte = c;
		r.arg_one = a1;
		r.arg_two = a2;
		r.pcm_byte = pcm;
		return r;
	endfunction

	function automatic cmd_t random_request();
		cmd_t r;
		int   sel;
		int   op_sel;
		r = make_request(OP_RUN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		op_sel = $urandom_range(99);
		sel = $urandom_range(99);
		if (op_sel >= 96) begin
			r.op = OP_UNUSED;
		end else if (op_sel >= 92) begin
			r.op = OP_START;
		end else if (op_sel >= 88) begin
			r.op = OP_RESET;
		end else if (sel < 25) begin
			r.command_byte = CMD_PSG;
		end else if (sel < 50) begin
			r.command_byte = $urandom_range(1) ? CMD_FM_PORT1 : CMD_FM_PORT0;
		end else if (sel < 58) begin
			r.command_byte = CMD_WAIT;
		end else if (sel < 61) begin
			r.command_byte = CMD_WAIT_NTSC;
		end else if (sel < 64) begin
			r.command_byte = CMD_WAIT_PAL;
		end else if (sel < 72) begin
			r.command_byte = CMD_SHORT_LO | 8'($urandom_range(15));
		end else if (sel < 82) begin
			r.command_byte = CMD_DAC_LO | 8'($urandom_range(15));
		end else if (sel < 88) begin
			r.command_byte = $urandom_range(1) ? CMD_SILENT
				: CMD_NOP_LO + 8'($urandom_range(5));
		end
		return r;
	endfunction

	// request side: hold until taken, then advance or idle
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || req_taken)) begin
			if (pending_cmds.size() != 0
					&& (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result side: stall at random outside the calm window
	always @(negedge clk) begin
		phase_stall <= arst_n && !calm && ($urandom_range(99) < IDLE_PERCENT);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("vgm_command_bus_sequencer regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		req_taken <= cmd_valid && !cmd_stall;
		if (cmd_valid && !cmd_stall) begin
			sequence_phases(cmd);
			requests_taken <= requests_taken + 1;
		end
		if (phase_valid && !phase_stall) begin
			if (phases_due.size() == 0) begin
				report_mismatch("unexpected result", 32'(phase.control_out), 32'd0);
			end else begin
				due_phase = phases_due.pop_front();
				if (phase.bus_valid !== due_phase.bus_valid)
					report_mismatch("bus_valid", 32'(phase.bus_valid), 32'(due_phase.bus_valid));
				if (phase.control_out !== due_phase.control_out)
					report_mismatch("control_out", 32'(phase.control_out),
						32'(due_phase.control_out));
				if (phase.data_out !== due_phase.data_out)
					report_mismatch("data_out", 32'(phase.data_out), 32'(due_phase.data_out));
				if (phase.next_sample_out !== due_phase.next_sample_out)
					report_mismatch("next_sample_out", phase.next_sample_out,
						due_phase.next_sample_out);
				if (phase.error !== due_phase.error)
					report_mismatch("error", 32'(phase.error), 32'(due_phase.error));
				if (phase.last !== due_phase.last)
					report_mismatch("last", 32'(phase.last), 32'(due_phase.last));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		phase_stall = 1'b0;
		req_taken = 1'b0;
		mismatches = 0;
		requests_taken = 0;
		cycle_count = 0;
		ctl_model = CTL_RESET;
		data_model = '0;
		sample_model = '0;

		pending_cmds.push_back(make_request(OP_START, 8'h00, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_PSG, 8'h00, 8'hff, 8'hff));
		pending_cmds.push_back(make_request(OP_RUN, CMD_PSG, 8'hff, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_PSG, 8'h01, 8'h5a, 8'ha5));
		pending_cmds.push_back(make_request(OP_RUN, CMD_FM_PORT0, 8'h00, 8'hff, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_FM_PORT1, 8'hff, 8'h00, 8'hff));
		pending_cmds.push_back(make_request(OP_RUN, CMD_FM_PORT0, 8'h80, 8'h01, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_WAIT, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_WAIT, 8'hff, 8'hff, 8'hff));
		pending_cmds.push_back(make_request(OP_RUN, CMD_WAIT_NTSC, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_WAIT_PAL, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_SHORT_LO, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_SHORT_HI, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_DAC_LO, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_DAC_HI, 8'hff, 8'hff, 8'hff));
		pending_cmds.push_back(make_request(OP_RUN, CMD_SILENT, 8'h12, 8'h34, 8'h56));
		pending_cmds.push_back(make_request(OP_RUN, CMD_NOP_LO, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, CMD_NOP_HI, 8'hff, 8'hff, 8'hff));
		pending_cmds.push_back(make_request(OP_RUN, CMD_NOP_HI + 8'd1, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, 8'h00, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RUN, 8'hff, 8'hff, 8'hff, 8'hff));
		pending_cmds.push_back(make_request(OP_RESET, 8'h00, 8'h00, 8'h00, 8'h00));
		pending_cmds.push_back(make_request(OP_RESET, 8'hff, 8'hff, 8'hff, 8'hff));
		pending_cmds.push_back(make_request(OP_UNUSED, CMD_PSG, 8'h33, 8'h44, 8'h55));
		pending_cmds.push_back(make_request(OP_START, 8'hff, 8'hff, 8'hff, 8'hff));
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			pending_cmds.push_back(random_request());
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || cmd_valid) @(posedge clk);
		while (phases_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("vgm_command_bus_sequencer regression: pass");
		end else begin
			$display("vgm_command_bus_sequencer regression: fail");
		end
		$finish;
	end

endmodule
